>>> hw/rtl/rfbd_pkg.sv
package rfbd_pkg;

    // default ring size, must be a power of two
    localparam int RING_SIZE_DEF = 64;

    localparam int MSG_W = 64;

    typedef logic [1:0]       t_status;
    typedef logic [MSG_W-1:0] t_msg;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

>>> hw/rtl/rfbd_if.sv
// input word channel
interface rfbd_in_if;
    import rfbd_pkg::*;

    logic valid;
    logic ready;
    logic op;
    t_msg message_in;

    modport source (output valid, output op, output message_in, input ready);
    modport sink   (input valid, input op, input message_in, output ready);
endinterface

// result word channel
interface rfbd_out_if;
    import rfbd_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_msg    message_out;
    logic    ring_full_flag;
    logic    ring_empty_flag;

    modport source (output valid, output status, output message_out,
                    output ring_full_flag, output ring_empty_flag, input ready);
    modport sink   (input valid, input status, input message_out,
                    input ring_full_flag, input ring_empty_flag, output ready);
endinterface

>>> hw/rtl/ring_fifo_with_batched_dequeue_unit.sv
// enqueue, empty dequeue, direct ring dequeue and dequeue from the batch store each pass
//   through S_RESP, which loads the registered read data into the result register
// a dequeue that refills the batch store runs through S_COPY, one ring read per entry
// a new word is taken only in S_IDLE with a free result register; words never overlap
// reset (synchronous, active low) clears counters and control; both memories keep
//   their contents and need no clearing pass
module ring_fifo_with_batched_dequeue_unit #(
    parameter int RING_SIZE = rfbd_pkg::RING_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfbd_in_if.sink     i_in,
    rfbd_out_if.source  o_out
);
    import rfbd_pkg::*;

    localparam int AW = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] MASK    = {AW{1'b1}};
    localparam logic [CW-1:0] SIZE_C  = CW'(RING_SIZE);
    localparam logic [CW-1:0] MIN_BAT = CW'(2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RESP = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_RING  = 2'd1;
    localparam logic [1:0] SRC_BATCH = 2'd2;

    // memories
    t_msg ring_mem  [RING_SIZE];
    t_msg batch_mem [RING_SIZE];

    // control registers
    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_enq, n_enq;
    logic [AW-1:0] r_deq, n_deq;
    logic [AW-1:0] r_sdq, n_sdq;
    logic [AW-1:0] r_sev, n_sev;
    logic [CW-1:0] r_batch_len, n_batch_len;
    logic [CW-1:0] r_batch_pos, n_batch_pos;
    logic [1:0]    r_src, n_src;
    t_status       r_pend, n_pend;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_wr_valid, n_wr_valid;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic          r_out_valid, n_out_valid;

    // payload registers
    t_msg    r_first, n_first;
    t_msg    r_ring_rdata;
    t_msg    r_batch_rdata;
    t_status r_out_status;
    t_msg    r_out_msg;
    logic    r_out_full;
    logic    r_out_empty;

    // memory access controls
    logic          ring_we;
    logic [AW-1:0] ring_waddr;
    logic [AW-1:0] ring_raddr;
    logic          batch_we;
    logic [AW-1:0] batch_waddr;
    t_msg          batch_wdata;
    logic [AW-1:0] batch_raddr;

    logic    accept;
    logic    out_load;
    t_status out_status;
    t_msg    out_msg;
    logic    full_now;
    logic    empty_now;

    // dequeue-side depth computation
    logic [AW-1:0] sdq_use;
    logic [AW-1:0] sev_use;
    logic [AW-1:0] depth1;
    logic [CW-1:0] room;
    logic [CW-1:0] clip;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign full_now   = (AW'(r_enq - r_deq) == MASK);
    assign empty_now  = (r_sev == r_deq);

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_enq       = r_enq;
        n_deq       = r_deq;
        n_sdq       = r_sdq;
        n_sev       = r_sev;
        n_batch_len = r_batch_len;
        n_batch_pos = r_batch_pos;
        n_src       = r_src;
        n_pend      = r_pend;
        n_head      = r_head;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_wr_valid  = r_wr_valid;
        n_wr_idx    = r_wr_idx;
        n_first     = r_first;
        ring_we     = 1'b0;
        ring_waddr  = r_enq;
        ring_raddr  = AW'(r_head + r_cnt[AW-1:0]);
        batch_we    = 1'b0;
        batch_waddr = r_wr_idx;
        batch_wdata = r_ring_rdata;
        batch_raddr = r_batch_pos[AW-1:0];
        out_load    = 1'b0;
        out_status  = r_pend;
        out_msg     = '0;
        sdq_use     = (AW'(r_enq - r_sdq) == MASK) ? r_deq : r_sdq;
        sev_use     = (AW'(r_sev - r_deq) == '0) ? r_enq : r_sev;
        depth1      = AW'(sev_use - r_deq);
        room        = SIZE_C - {1'b0, r_deq};
        clip        = ({1'b0, depth1} > room) ? room : {1'b0, depth1};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RESP;
                    n_src   = SRC_NONE;
                    n_pend  = ST_OK;
                    if (i_in.op == OP_ENQ) begin
                        // enqueue with refresh of the saved dequeue count
                        n_sdq = sdq_use;
                        if (AW'(r_enq - sdq_use) == MASK) begin
                            n_pend = ST_FULL;
                        end else begin
                            ring_we = 1'b1;
                            n_enq   = AW'(r_enq + 1'b1);
                        end
                    end else if (r_batch_len != '0) begin
                        // serve from the batch store
                        n_src       = SRC_BATCH;
                        n_batch_pos = CW'(r_batch_pos + 1'b1);
                        if (CW'(r_batch_pos + 1'b1) == r_batch_len) begin
                            n_batch_len = '0;
                        end
                    end else begin
                        n_sev = sev_use;
                        if (depth1 == '0) begin
                            n_pend = ST_EMPTY;
                        end else if (clip > MIN_BAT) begin
                            // start a batch refill
                            n_state     = S_COPY;
                            n_head      = r_deq;
                            n_depth     = clip;
                            n_cnt       = '0;
                            n_batch_len = clip;
                            n_batch_pos = CW'(1);
                            n_deq       = AW'(r_deq + clip[AW-1:0]);
                        end else begin
                            // direct read at the head
                            ring_raddr = r_deq;
                            n_src      = SRC_RING;
                            n_deq      = AW'(r_deq + 1'b1);
                        end
                    end
                end
            end
            S_RESP: begin
                out_load = 1'b1;
                case (r_src)
                    SRC_RING:  out_msg = r_ring_rdata;
                    SRC_BATCH: out_msg = r_batch_rdata;
                    default:   out_msg = '0;
                endcase
                n_state = S_IDLE;
            end
            S_COPY: begin
                // issue one ring read per cycle
                if (r_cnt != r_depth) begin
                    n_cnt      = CW'(r_cnt + 1'b1);
                    n_wr_valid = 1'b1;
                    n_wr_idx   = r_cnt[AW-1:0];
                end else begin
                    n_wr_valid = 1'b0;
                end
                // write back the word read last cycle
                if (r_wr_valid) begin
                    batch_we = 1'b1;
                    if (r_wr_idx == '0) begin
                        n_first = r_ring_rdata;
                    end
                end
                if ((r_cnt == r_depth) && r_wr_valid) begin
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_msg    = r_first;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= i_in.message_in;
        end
        r_ring_rdata <= ring_mem[ring_raddr];
    end

    // batch memory
    always_ff @(posedge i_clk) begin
        if (batch_we) begin
            batch_mem[batch_waddr] <= batch_wdata;
        end
        r_batch_rdata <= batch_mem[batch_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enq       <= '0;
            r_deq       <= '0;
            r_sdq       <= '0;
            r_sev       <= '0;
            r_batch_len <= '0;
            r_batch_pos <= '0;
            r_src       <= SRC_NONE;
            r_pend      <= ST_OK;
            r_head      <= '0;
            r_depth     <= '0;
            r_cnt       <= '0;
            r_wr_valid  <= 1'b0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_enq       <= n_enq;
            r_deq       <= n_deq;
            r_sdq       <= n_sdq;
            r_sev       <= n_sev;
            r_batch_len <= n_batch_len;
            r_batch_pos <= n_batch_pos;
            r_src       <= n_src;
            r_pend      <= n_pend;
            r_head      <= n_head;
            r_depth     <= n_depth;
            r_cnt       <= n_cnt;
            r_wr_valid  <= n_wr_valid;
            r_wr_idx    <= n_wr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_msg    <= out_msg;
            r_out_full   <= full_now;
            r_out_empty  <= empty_now;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.message_out     = r_out_msg;
    assign o_out.ring_full_flag  = r_out_full;
    assign o_out.ring_empty_flag = r_out_empty;

`ifndef SYNTHESIS
    // batch read position stays inside an active batch
    a_batch_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_batch_len != '0) |-> (r_batch_pos < r_batch_len))
        else $error("batch position past batch length");

    // batch never longer than the ring
    a_batch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_batch_len <= SIZE_C)
        else $error("batch length exceeds ring size");

    // a refused enqueue reports a full ring
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> r_out_full)
        else $error("full status without full flag");

    // an empty dequeue reports an empty ring
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_EMPTY)) |-> r_out_empty)
        else $error("empty status without empty flag");

    // a refill writes the batch store only while copying
    a_copy_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_valid |-> (r_state == S_COPY))
        else $error("batch write outside refill");
`endif

endmodule
